// ----- rtl/sdq_pkg.sv -----
// Shared types and codes for the sorted delay queue.
// No dependencies; used by sdq_ctrl, sdq_datapath and sorted_delay_queue_top.
package sdq_pkg;

    localparam int ID_W   = 16;
    localparam int WAIT_W = 16;
    localparam int KIND_W = 2;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd2;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DECR,
        ST_RELEASE
    } sdq_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic insert;
        logic decr;
        logic pop;
    } sdq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic front_expired;
        logic pop_last;
        logic req_is_tick;
    } sdq_status_t;

endpackage

// ----- rtl/sdq_ctrl.sv -----
// Controller state machine for the sorted delay queue.
// Depends on sdq_pkg; drives commands into sdq_datapath.
module sdq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdq_pkg::sdq_status_t status,
    output sdq_pkg::sdq_cmd_t   cmd
);

    sdq_pkg::sdq_state_t state_reg;
    sdq_pkg::sdq_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one beat: capture, then insert or decrement and release
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            sdq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sdq_pkg::ST_INSERT;
                end
            end
            sdq_pkg::ST_INSERT:
            begin
                if (status.req_is_tick)
                begin
                    cmd.decr   = 1'b1;
                    state_next = sdq_pkg::ST_RELEASE;
                end
                else if (status.out_free)
                begin
                    cmd.insert = 1'b1;
                    state_next = sdq_pkg::ST_IDLE;
                end
            end
            sdq_pkg::ST_DECR:
            begin
                cmd.decr   = 1'b1;
                state_next = sdq_pkg::ST_RELEASE;
            end
            sdq_pkg::ST_RELEASE:
            begin
                if (!status.front_expired)
                begin
                    state_next = sdq_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.pop = 1'b1;
                    if (status.pop_last)
                    begin
                        state_next = sdq_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sdq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sdq_datapath.sv -----
// Datapath of the sorted delay queue: row of sorted slots, item and result registers.
// Depends on sdq_pkg; commanded by sdq_ctrl.
module sdq_datapath
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TICK_BITS   = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_type,
    input  logic [sdq_pkg::ID_W-1:0]     proc_id,
    input  logic [sdq_pkg::WAIT_W-1:0]   wait_ticks,
    input  sdq_pkg::sdq_cmd_t            cmd,
    output sdq_pkg::sdq_status_t         status,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sdq_pkg::KIND_W-1:0]   kind,
    output logic [sdq_pkg::ID_W-1:0]     released_id,
    output logic                         last_of_run
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    // Captured item
    logic                       req_reg;
    logic [sdq_pkg::ID_W-1:0]   pid_reg;
    logic [TICK_BITS-1:0]       wait_reg;

    // Slot row, front at index 0
    logic [sdq_pkg::ID_W-1:0]   slot_id_reg   [QUEUE_DEPTH];
    logic [sdq_pkg::ID_W-1:0]   slot_id_next  [QUEUE_DEPTH];
    logic [TICK_BITS-1:0]       slot_rem_reg  [QUEUE_DEPTH];
    logic [TICK_BITS-1:0]       slot_rem_next [QUEUE_DEPTH];
    logic [OCC_W-1:0]           occ_reg;
    logic [OCC_W-1:0]           occ_next;

    // Result register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [sdq_pkg::KIND_W-1:0] kind_reg;
    logic [sdq_pkg::KIND_W-1:0] kind_next;
    logic [sdq_pkg::ID_W-1:0]   rid_reg;
    logic [sdq_pkg::ID_W-1:0]   rid_next;
    logic                       last_reg;
    logic                       last_next;

    logic                       full;
    logic                       load;
    logic [QUEUE_DEPTH-1:0]     stay;

    assign full = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign load = cmd.insert || cmd.pop;

    // Status towards the controller
    assign status.out_free      = !out_valid_reg || out_ready;
    assign status.front_expired = (occ_reg != '0) && (slot_rem_reg[0] == '0);
    assign status.pop_last      = (occ_reg == OCC_W'(1)) || (slot_rem_reg[1] != '0);
    assign status.req_is_tick   = (req_reg == sdq_pkg::REQ_TICK);

    // Latch the item on capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            pid_reg  <= proc_id;
            wait_reg <= TICK_BITS'(wait_ticks);
        end
    end

    // Mark slots that stay put on insert: valid and not later than the new wait
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            stay[i] = (occ_reg > OCC_W'(i)) && (slot_rem_reg[i] <= wait_reg);
        end
    end

    // Insert, decrement or pop the slot row
    always_comb
    begin
        occ_next = occ_reg;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_id_next[i]  = slot_id_reg[i];
            slot_rem_next[i] = slot_rem_reg[i];
        end
        if (cmd.insert && !full)
        begin
            occ_next = occ_reg + OCC_W'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (stay[i])
                begin
                    slot_id_next[i]  = slot_id_reg[i];
                    slot_rem_next[i] = slot_rem_reg[i];
                end
                else if (i == 0 || stay[(i == 0) ? 0 : i - 1])
                begin
                    slot_id_next[i]  = pid_reg;
                    slot_rem_next[i] = wait_reg;
                end
                else
                begin
                    slot_id_next[i]  = slot_id_reg[(i == 0) ? 0 : i - 1];
                    slot_rem_next[i] = slot_rem_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
        else if (cmd.decr)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (slot_rem_reg[i] != '0)
                begin
                    slot_rem_next[i] = slot_rem_reg[i] - TICK_BITS'(1);
                end
            end
        end
        else if (cmd.pop)
        begin
            occ_next = occ_reg - OCC_W'(1);
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                slot_id_next[i]  = slot_id_reg[i + 1];
                slot_rem_next[i] = slot_rem_reg[i + 1];
            end
        end
    end

    // Advance the slot row
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_id_reg[i]  <= slot_id_next[i];
            slot_rem_reg[i] <= slot_rem_next[i];
        end
    end

    // Load the result register, drop it once the beat is taken
    always_comb
    begin
        kind_next = kind_reg;
        rid_next  = rid_reg;
        last_next = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
        if (cmd.insert)
        begin
            kind_next = full ? sdq_pkg::KIND_REJECTED : sdq_pkg::KIND_ACCEPTED;
            rid_next  = pid_reg;
            last_next = 1'b1;
        end
        else if (cmd.pop)
        begin
            kind_next = sdq_pkg::KIND_RELEASED;
            rid_next  = slot_id_reg[0];
            last_next = status.pop_last;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        rid_reg  <= rid_next;
        last_reg <= last_next;
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign released_id = rid_reg;
    assign last_of_run = last_reg;

endmodule

// ----- rtl/sorted_delay_queue_top.sv -----
// Sorted delay queue top level: wires the controller to the datapath.
// Depends on sdq_pkg, sdq_ctrl and sdq_datapath.
//
// Delay queue of sleeping process ids held in ascending order of remaining
// ticks, in a row of QUEUE_DEPTH slots. An insert beat (req_type 0) is
// captured, then placed at its sorted position by a parallel compare-and-shift
// of the whole row once the output register is free; it answers kind 0
// (accepted) or kind 1 (full). A tick beat (req_type 1) is captured, then every
// slot is decremented, then each expired process is released in turn, one
// release per cycle while the output register is free; the last release
// carries last_of_run. Each result waits in a single output register, so a
// stalled consumer holds inserts and the release sequence one beat at a time
// for as long as the register stays full. No clearing pass is needed after
// reset.
module sorted_delay_queue_top
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TICK_BITS   = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  logic [sdq_pkg::ID_W-1:0]    proc_id,
    input  logic [sdq_pkg::WAIT_W-1:0]  wait_ticks,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sdq_pkg::KIND_W-1:0]  kind,
    output logic [sdq_pkg::ID_W-1:0]    released_id,
    output logic                        last_of_run
);

    sdq_pkg::sdq_cmd_t    cmd;
    sdq_pkg::sdq_status_t status;

    sdq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sdq_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICK_BITS   (TICK_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req_type),
        .proc_id     (proc_id),
        .wait_ticks  (wait_ticks),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .released_id (released_id),
        .last_of_run (last_of_run)
    );

endmodule
